// ----- rtl/isbt_pkg.sv -----
// Shared constants and helpers for the interleaved subarray base translator.
// No dependencies; used by the top level and its checker.
package isbt_pkg;

	localparam int ADDR_W    = 64;
	localparam int KLOG_W    = 3;
	localparam int LO_W      = 6;
	localparam int ROWS_W    = 16;
	localparam int ROWB_W    = 16;
	localparam int RBYTE_W   = ROWB_W - 3;       // bytes per row = bits >> 3
	localparam int SA_W      = ROWS_W + RBYTE_W; // subarray size in bytes
	localparam int CH_W      = 1 << KLOG_W;      // widest channel field, minus one spare
	localparam int CHF_W     = CH_W - 1;         // k is at most 7
	localparam int POS_W     = LO_W + 1;         // lo + k can reach 70
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = ADDR_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN_LOG2   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ILV_LO      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BITS    = 3'd4;

	// reset values
	localparam logic [ADDR_W-1:0] RST_WINDOW_BASE = '0;
	localparam logic [KLOG_W-1:0] RST_CHAN_LOG2   = 3'd0;
	localparam logic [LO_W-1:0]   RST_ILV_LO      = 6'd6;
	localparam logic [ROWS_W-1:0] RST_ROWS        = 16'd512;
	localparam logic [ROWB_W-1:0] RST_ROW_BITS    = 16'd1024;

	// mask of all bits below pos; all ones once pos reaches the word width
	function automatic logic [ADDR_W-1:0] bits_below(input logic [POS_W-1:0] pos);
		logic [ADDR_W-1:0] m;
		m = ~({ADDR_W{1'b1}} << pos[LO_W-1:0]);
		if (pos[LO_W]) begin
			m = {ADDR_W{1'b1}};
		end
		return m;
	endfunction

	// drop the k-bit field at bit lo and close the gap
	function automatic logic [ADDR_W-1:0] squeeze(input logic [ADDR_W-1:0] v,
			input logic [LO_W-1:0] lo, input logic [KLOG_W-1:0] k);
		logic [ADDR_W-1:0] low;
		logic [ADDR_W-1:0] high;
		low  = v & bits_below({1'b0, lo});
		high = v & ~bits_below({1'b0, lo} + {{(POS_W-KLOG_W){1'b0}}, k});
		return (high >> k) | low;
	endfunction

endpackage

// ----- rtl/interleaved_subarray_base_translate.sv -----
// Interleaved subarray base translator: config registers, squeeze stage, 64-step
// radix-2 remainder pipeline, combine stage and output skid. Uses isbt_pkg.
// Path: the item passes 68 registers (squeeze, 65 remainder, combine, output),
// the first loads at the accepting edge.
// Throughput: 1 item per cycle while the skid is empty; depth is set by the one-bit-per-stage remainder.
// Reset: arst_n clears all valid bits and the skid; config takes its defaults.
module interleaved_subarray_base_translate (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port
	input  logic                               cfg_we,
	input  logic [isbt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [isbt_pkg::CFG_W-1:0]         cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [isbt_pkg::ADDR_W-1:0]        phys_addr,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [isbt_pkg::ADDR_W-1:0]        subarray_start
);

	localparam int AW    = isbt_pkg::ADDR_W;
	localparam int SW    = isbt_pkg::SA_W;
	localparam int CW    = isbt_pkg::CHF_W;
	localparam int NDIV  = AW;  // one quotient bit per stage

	// ------------------------------------------------------------------
	// Config registers. The user must write only while the pipe is empty; the block does not enforce it.
	// ------------------------------------------------------------------
	logic [AW-1:0]                   window_base_q;
	logic [isbt_pkg::KLOG_W-1:0]     chan_log2_q;
	logic [isbt_pkg::LO_W-1:0]       ilv_lo_q;
	logic [isbt_pkg::ROWS_W-1:0]     rows_q;
	logic [isbt_pkg::ROWB_W-1:0]     row_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q <= isbt_pkg::RST_WINDOW_BASE;
			chan_log2_q   <= isbt_pkg::RST_CHAN_LOG2;
			ilv_lo_q      <= isbt_pkg::RST_ILV_LO;
			rows_q        <= isbt_pkg::RST_ROWS;
			row_bits_q    <= isbt_pkg::RST_ROW_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				isbt_pkg::REG_WINDOW_BASE: window_base_q <= cfg_data;
				isbt_pkg::REG_CHAN_LOG2:   chan_log2_q   <= cfg_data[isbt_pkg::KLOG_W-1:0];
				isbt_pkg::REG_ILV_LO:      ilv_lo_q      <= cfg_data[isbt_pkg::LO_W-1:0];
				isbt_pkg::REG_ROWS:        rows_q        <= cfg_data[isbt_pkg::ROWS_W-1:0];
				isbt_pkg::REG_ROW_BITS:    row_bits_q    <= cfg_data[isbt_pkg::ROWB_W-1:0];
				default: ;
			endcase
		end
	end

	// Values derived from config, registered once. They are first read at
	// the remainder stages.
	logic [SW-1:0] sa_c;
	logic [SW-1:0] sa_q;
	logic          sa_zero_q;
	logic [AW-1:0] sq_base_q;

	assign sa_c = {{(SW-isbt_pkg::ROWS_W){1'b0}}, rows_q}
		* {{(SW-isbt_pkg::RBYTE_W){1'b0}}, row_bits_q[isbt_pkg::ROWB_W-1:3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_q      <= '0;
			sa_zero_q <= 1'b1;
			sq_base_q <= '0;
		end else begin
			sa_q      <= sa_c;
			sa_zero_q <= (sa_c == '0);
			sq_base_q <= isbt_pkg::squeeze(window_base_q, ilv_lo_q, chan_log2_q);
		end
	end

	// ------------------------------------------------------------------
	// Flow control. The whole pipe moves unless the skid holds an item;
	// the skid catches the one item that drains while the output waits.
	// ------------------------------------------------------------------
	logic adv;
	logic take;
	logic skid_q;
	logic out_valid_q;

	assign adv      = !skid_q;
	assign take     = out_valid_q && !out_stall;
	assign in_stall = skid_q;

	// ------------------------------------------------------------------
	// Stage 1: squeeze out the channel field, keep the channel bits.
	// ------------------------------------------------------------------
	logic          v_s1;
	logic [AW-1:0] sq_addr_s1;
	logic [CW-1:0] ch_s1;
	logic [CW-1:0] ch_mask;

	assign ch_mask = ~({CW{1'b1}} << chan_log2_q);

	// Stage 2 is remainder stage 0: offset from the base, partial rem cleared.
	// Index i of the arrays below holds the item after i quotient bits.
	logic          div_v_s   [0:NDIV];
	logic [AW-1:0] div_off_s [0:NDIV];
	logic [SW-1:0] div_rem_s [0:NDIV];
	logic [CW-1:0] div_ch_s  [0:NDIV];
	logic [SW-1:0] rem_nx    [0:NDIV-1];

	// restoring step: shift in the next offset bit, subtract when it fits
	always_comb begin
		logic [SW:0] trial;
		for (int i = 0; i < NDIV; i++) begin
			trial = {div_rem_s[i], div_off_s[i][AW-1-i]};
			if (trial >= {1'b0, sa_q}) begin
				rem_nx[i] = SW'(trial - {1'b0, sa_q});
			end else begin
				rem_nx[i] = trial[SW-1:0];
			end
		end
	end

	// Combine stage: aligned offset, and base plus the channel bits in place.
	logic          v_t1;
	logic [AW-1:0] aligned_t1;
	logic [AW-1:0] basech_t1;
	logic [AW-1:0] res_c;

	assign res_c = sa_zero_q ? window_base_q : basech_t1 + (aligned_t1 << chan_log2_q);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i <= NDIV; i++) begin
				div_v_s[i] <= 1'b0;
			end
			v_t1 <= 1'b0;
		end else if (adv) begin
			v_s1       <= in_valid;
			div_v_s[0] <= v_s1;
			for (int i = 1; i <= NDIV; i++) begin
				div_v_s[i] <= div_v_s[i-1];
			end
			v_t1 <= div_v_s[NDIV];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_addr_s1   <= isbt_pkg::squeeze(phys_addr, ilv_lo_q, chan_log2_q);
			ch_s1        <= CW'(phys_addr >> ilv_lo_q) & ch_mask;
			div_off_s[0] <= sq_addr_s1 - sq_base_q;
			div_rem_s[0] <= '0;
			div_ch_s[0]  <= ch_s1;
			for (int i = 1; i <= NDIV; i++) begin
				div_off_s[i] <= div_off_s[i-1];
				div_rem_s[i] <= rem_nx[i-1];
				div_ch_s[i]  <= div_ch_s[i-1];
			end
			aligned_t1 <= div_off_s[NDIV] - {{(AW-SW){1'b0}}, div_rem_s[NDIV]};
			basech_t1  <= window_base_q + ({{(AW-CW){1'b0}}, div_ch_s[NDIV]} << ilv_lo_q);
		end
	end

	// ------------------------------------------------------------------
	// Output register and skid.
	// ------------------------------------------------------------------
	logic          load_out;
	logic          load_skid;
	logic [AW-1:0] out_data_q;
	logic [AW-1:0] skid_data_q;

	assign load_out  = !skid_q && v_t1 && (!out_valid_q || take);
	assign load_skid = !skid_q && v_t1 && out_valid_q && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_q      <= 1'b0;
		end else if (skid_q) begin
			if (take) begin
				skid_q <= 1'b0;  // skid item moves up, output stays valid
			end
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (load_skid) begin
			skid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_q && take) begin
			out_data_q <= skid_data_q;
		end else if (load_out) begin
			out_data_q <= res_c;
		end
		if (load_skid) begin
			skid_data_q <= res_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign subarray_start = out_data_q;

endmodule

// ----- rtl/isbt_checker.sv -----
// Port-level checks for the interleaved subarray base translator, with bind.
// Depends on isbt_pkg and the top level's port names.
module isbt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [isbt_pkg::ADDR_W-1:0] subarray_start
);

	// input side only backs up once a result sat stalled at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall rose without a stalled result");

	// a held skid item means a result is also showing
	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// one result taken frees the input side
	a_stall_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("input stall held after result was taken");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(subarray_start))
		else $error("stalled result changed or dropped");

	// handshake outputs are always known once out of reset
	a_hs_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid}))
		else $error("handshake output unknown");

endmodule

bind interleaved_subarray_base_translate isbt_checker u_isbt_checker (.*);
